[design/body_rate_euler_integrator_macros.svh]
// Assertion macros used by the body rate integrator checker.
`ifndef BODY_RATE_EULER_INTEGRATOR_MACROS_SVH
`define BODY_RATE_EULER_INTEGRATOR_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define BREI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define BREI_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[design/brei_pkg.sv]
// Types and constants shared by the body rate integrator modules.
`timescale 1ns / 1ps
package brei_pkg;

    // Configuration register file
    localparam int CFG_ADDR_W = 2;
    localparam int INERTIA_W  = 31;
    localparam int STEP_W     = 17;
    localparam int CFG_DATA_W = INERTIA_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_ROLL_INERTIA  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TRANS_INERTIA = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_TIME_STEP     = 2'd2;

    localparam logic [INERTIA_W-1:0] INERTIA_RST   = 31'd65536;
    localparam logic [STEP_W-1:0]    TIME_STEP_RST = 17'd655;

    // rad/s to deg/s scale, Q16.16 (57.2958)
    localparam int               DEG_CONST_W  = 23;
    localparam logic [DEG_CONST_W-1:0] RAD2DEG_Q16 = 23'd3754936;
    localparam int               DEG_SHIFT    = 16;

    typedef enum logic [1:0] {
        AX_ROLL,
        AX_PITCH,
        AX_YAW
    } axis_t;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_MUL_INT,
        OP_WB_INT,
        OP_MUL_DR,
        OP_WB_T1,
        OP_MUL_T,
        OP_WB_T,
        OP_MUL_DEG,
        OP_WB_DEG,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        axis_t  axis;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV,
        ST_DIV_FIN,
        ST_MUL_INT,
        ST_WB_INT,
        ST_MUL_DR,
        ST_WB_T1,
        ST_MUL_T,
        ST_WB_T,
        ST_MUL_DEG,
        ST_WB_DEG,
        ST_OUT
    } ctrl_state_t;

endpackage

[design/brei_ctrl.sv]
// Sequencer for the body rate integrator: one item at a time through the datapath.
`timescale 1ns / 1ps
module brei_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  brei_pkg::dp_status_t status,
    output brei_pkg::dp_cmd_t    cmd
);
    import brei_pkg::*;

    ctrl_state_t state_reg, state_next;
    axis_t       axis_reg, axis_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        out_free;

    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIV_START;
                    axis_next  = AX_ROLL;
                end
            end
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_last) state_next = ST_DIV_FIN;
            end
            ST_DIV_FIN: state_next = ST_MUL_INT;
            ST_MUL_INT: state_next = ST_WB_INT;
            ST_WB_INT: begin
                unique case (axis_reg)
                    AX_ROLL: begin
                        axis_next  = AX_PITCH;
                        state_next = ST_MUL_DR;
                    end
                    AX_PITCH: begin
                        axis_next  = AX_YAW;
                        state_next = ST_MUL_T;
                    end
                    AX_YAW: begin
                        axis_next  = AX_ROLL;
                        state_next = ST_MUL_DEG;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_MUL_DR: state_next = ST_WB_T1;
            ST_WB_T1:  state_next = ST_MUL_T;
            ST_MUL_T:  state_next = ST_WB_T;
            ST_WB_T:   state_next = ST_DIV_START;
            ST_MUL_DEG: state_next = ST_WB_DEG;
            ST_WB_DEG: begin
                unique case (axis_reg)
                    AX_ROLL: begin
                        axis_next  = AX_PITCH;
                        state_next = ST_MUL_DEG;
                    end
                    AX_PITCH: begin
                        axis_next  = AX_YAW;
                        state_next = ST_MUL_DEG;
                    end
                    AX_YAW:  state_next = ST_OUT;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        cmd.axis = axis_reg;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      cmd.op = accept ? OP_LOAD : OP_NONE;
            ST_DIV_START: cmd.op = OP_DIV_START;
            ST_DIV:       cmd.op = OP_DIV_STEP;
            ST_DIV_FIN:   cmd.op = OP_DIV_FIN;
            ST_MUL_INT:   cmd.op = OP_MUL_INT;
            ST_WB_INT:    cmd.op = OP_WB_INT;
            ST_MUL_DR:    cmd.op = OP_MUL_DR;
            ST_WB_T1:     cmd.op = OP_WB_T1;
            ST_MUL_T:     cmd.op = OP_MUL_T;
            ST_WB_T:      cmd.op = OP_WB_T;
            ST_MUL_DEG:   cmd.op = OP_MUL_DEG;
            ST_WB_DEG:    cmd.op = OP_WB_DEG;
            ST_OUT:       cmd.op = out_free ? OP_OUT : OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    // Output beat holding register
    always_comb begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_OUT) && out_free) out_valid_next = 1'b1;
        else if (m_tready)                     out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AX_ROLL;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

[design/brei_datapath.sv]
// Datapath: config registers, state, shared multiplier and 2-bit/cycle divider.
`timescale 1ns / 1ps
module brei_datapath #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [brei_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [brei_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [WORD_WIDTH-1:0]               roll_moment,
    input  logic [WORD_WIDTH-1:0]               pitch_moment,
    input  logic [WORD_WIDTH-1:0]               yaw_moment,
    input  brei_pkg::dp_cmd_t                   cmd,
    output brei_pkg::dp_status_t                status,
    output logic [WORD_WIDTH-1:0]               roll_rate_rad,
    output logic [WORD_WIDTH-1:0]               pitch_rate_rad,
    output logic [WORD_WIDTH-1:0]               yaw_rate_rad,
    output logic [WORD_WIDTH-1:0]               roll_rate_deg,
    output logic [WORD_WIDTH-1:0]               pitch_rate_deg,
    output logic [WORD_WIDTH-1:0]               yaw_rate_deg
);
    import brei_pkg::*;

    localparam int W   = WORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int RW  = INERTIA_W + 1;
    localparam int MAW = (W + 1 > RW) ? W + 1 : RW;
    localparam int MBW = (W + 1 > DEG_CONST_W + 1) ? W + 1 : DEG_CONST_W + 1;
    localparam int PW  = MAW + MBW;
    localparam int XW  = PW + 1;
    localparam int QN  = W + F + ((W + F) % 2);
    localparam int ND  = QN / 2;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;

    localparam logic signed [XW-1:0] SMAX = $signed({{(XW + 1 - W){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [XW-1:0] SMIN = ~SMAX;
    localparam logic [W-1:0]  WMAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  WMIN     = {1'b1, {(W-1){1'b0}}};
    localparam logic [QN-1:0] QMAX     = QN'({(W-1){1'b1}});
    localparam logic [QN-1:0] QMIN_MAG = QMAX + 1'b1;

    function automatic logic [W-1:0] sat_w(input logic signed [XW-1:0] x);
        if (x > SMAX)      sat_w = SMAX[W-1:0];
        else if (x < SMIN) sat_w = SMIN[W-1:0];
        else               sat_w = x[W-1:0];
    endfunction

    // Config registers
    logic [INERTIA_W-1:0] ri_reg, ti_reg;
    logic [STEP_W-1:0]    ts_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ri_reg <= INERTIA_RST;
            ti_reg <= INERTIA_RST;
            ts_reg <= TIME_STEP_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_IDX_ROLL_INERTIA)  ri_reg <= cfg_wdata;
            if (cfg_addr == CFG_IDX_TRANS_INERTIA) ti_reg <= cfg_wdata;
            if (cfg_addr == CFG_IDX_TIME_STEP)     ts_reg <= cfg_wdata[STEP_W-1:0];
        end
    end

    // Inertia difference, exact
    logic signed [RW-1:0] diff;
    assign diff = $signed({1'b0, ti_reg}) - $signed({1'b0, ri_reg});

    // Working registers
    logic signed [W-1:0]  mom_reg   [0:2];
    logic signed [W-1:0]  rate_reg  [0:2];
    logic signed [W-1:0]  accel_reg [0:2];
    logic signed [W-1:0]  deg_reg   [0:2];
    logic [W-1:0]         out_rad_reg [0:2];
    logic [W-1:0]         out_deg_reg [0:2];
    logic signed [W-1:0]  t1_reg, t_reg, acc_new_reg;
    logic signed [PW-1:0] p_reg, p_next;

    // Divider registers
    logic [QN-1:0]        q_reg, q_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [INERTIA_W-1:0] den_reg;
    logic                 neg_reg, nz_reg, dz_reg;
    logic [CW-1:0]        cnt_reg;

    // Divider operand select
    logic signed [W-1:0]  num;
    logic [W-1:0]         mag;
    logic [INERTIA_W-1:0] den_sel;

    always_comb begin
        unique case (cmd.axis)
            AX_PITCH: num = sat_w(XW'(t_reg) + XW'(mom_reg[AX_PITCH]));
            AX_YAW:   num = sat_w(XW'(mom_reg[AX_YAW]) - XW'(t_reg));
            default:  num = mom_reg[AX_ROLL];
        endcase
        den_sel = (cmd.axis == AX_ROLL) ? ri_reg : ti_reg;
        mag     = num[W-1] ? (~num + 1'b1) : num;
    end

    // Two restoring steps per cycle
    always_comb begin
        logic [RW-1:0] rs;
        rem_next = rem_reg;
        q_next   = q_reg;
        for (int k = 0; k < 2; k++) begin
            rs     = {rem_next[RW-2:0], q_next[QN-1]};
            q_next = {q_next[QN-2:0], 1'b0};
            if (rs >= {1'b0, den_reg}) begin
                rem_next  = rs - {1'b0, den_reg};
                q_next[0] = 1'b1;
            end else begin
                rem_next = rs;
            end
        end
    end

    // Signed, saturated quotient
    logic [W-1:0]  quot;
    logic [QN-1:0] q_neg;
    assign q_neg = ~q_reg + 1'b1;

    always_comb begin
        if (dz_reg)        quot = nz_reg ? (neg_reg ? WMIN : WMAX) : '0;
        else if (!neg_reg) quot = (q_reg > QMAX) ? WMAX : q_reg[W-1:0];
        else               quot = (q_reg > QMIN_MAG) ? WMIN : q_neg[W-1:0];
    end

    // Shared multiplier operand select
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [W:0]     acc_sum;

    assign acc_sum = (W+1)'(acc_new_reg) + (W+1)'(accel_reg[cmd.axis]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_MUL_INT: begin
                mul_a = MAW'(acc_sum);
                mul_b = $signed(MBW'(ts_reg));
            end
            OP_MUL_DR: begin
                mul_a = MAW'(diff);
                mul_b = MBW'(rate_reg[AX_ROLL]);
            end
            OP_MUL_T: begin
                mul_a = MAW'(t1_reg);
                mul_b = (cmd.axis == AX_PITCH) ? MBW'(rate_reg[AX_YAW])
                                               : MBW'(rate_reg[AX_PITCH]);
            end
            OP_MUL_DEG: begin
                mul_a = MAW'(rate_reg[cmd.axis]);
                mul_b = $signed(MBW'(RAD2DEG_Q16));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign p_next = mul_a * mul_b;

    // Product writeback values (floor shifts)
    logic signed [XW-1:0] p_ext;
    logic signed [XW-1:0] rate_sum;
    assign p_ext    = XW'(p_reg);
    assign rate_sum = XW'(rate_reg[cmd.axis]) + (p_ext >>> (F + 1));

    // State registers (cleared by reset)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                rate_reg[i]  <= '0;
                accel_reg[i] <= '0;
            end
        end else if (cmd.op == OP_WB_INT) begin
            rate_reg[cmd.axis]  <= sat_w(rate_sum);
            accel_reg[cmd.axis] <= acc_new_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                mom_reg[AX_ROLL]  <= roll_moment;
                mom_reg[AX_PITCH] <= pitch_moment;
                mom_reg[AX_YAW]   <= yaw_moment;
            end
            OP_DIV_START: begin
                q_reg   <= QN'({mag, {F{1'b0}}});
                rem_reg <= '0;
                den_reg <= den_sel;
                neg_reg <= num[W-1];
                nz_reg  <= (num != '0);
                dz_reg  <= (den_sel == '0);
                cnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_DIV_FIN: acc_new_reg <= quot;
            OP_MUL_INT, OP_MUL_DR, OP_MUL_T, OP_MUL_DEG: p_reg <= p_next;
            OP_WB_T1:  t1_reg <= sat_w(p_ext >>> F);
            OP_WB_T:   t_reg  <= sat_w(p_ext >>> F);
            OP_WB_DEG: deg_reg[cmd.axis] <= sat_w(p_ext >>> DEG_SHIFT);
            OP_OUT: begin
                for (int i = 0; i < 3; i++) begin
                    out_rad_reg[i] <= rate_reg[i];
                    out_deg_reg[i] <= deg_reg[i];
                end
            end
            default: ;
        endcase
    end

    assign status.div_last = (cnt_reg == CW'(ND - 1));

    assign roll_rate_rad  = out_rad_reg[AX_ROLL];
    assign pitch_rate_rad = out_rad_reg[AX_PITCH];
    assign yaw_rate_rad   = out_rad_reg[AX_YAW];
    assign roll_rate_deg  = out_deg_reg[AX_ROLL];
    assign pitch_rate_deg = out_deg_reg[AX_PITCH];
    assign yaw_rate_deg   = out_deg_reg[AX_YAW];

endmodule

[design/body_rate_euler_integrator.sv]
// Top level of the body rate Euler integrator.
//
//   channel  | direction | payload
//   s_       | in        | roll, pitch, yaw moments
//   m_       | out       | three rates in rad/s, then three in deg/s
//   cfg_     | in        | roll inertia, transverse inertia, time step
//
// Each beat runs the divider's 2-bit-per-cycle loop three times, and a new
// beat is accepted only after the last one has reached the output
// register. Sync reset clears state and rates to zero and
// the registers to their defaults. A result waits in the output register
// while the next beat is accepted; a stalled output holds the last step.
`timescale 1ns / 1ps
module body_rate_euler_integrator #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // roll_moment, pitch_moment, yaw_moment
    input  logic [((3*WORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // roll/pitch/yaw_rate_rad, roll/pitch/yaw_rate_deg
    output logic [((6*WORD_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [brei_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [brei_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import brei_pkg::*;

    localparam int W       = WORD_WIDTH;
    localparam int OUT_TDW = ((6*W+7)/8)*8;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [W-1:0] roll_rad, pitch_rad, yaw_rad, roll_deg, pitch_deg, yaw_deg;

    brei_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    brei_datapath #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .roll_moment    (s_tdata[W-1:0]),
        .pitch_moment   (s_tdata[2*W-1:W]),
        .yaw_moment     (s_tdata[3*W-1:2*W]),
        .cmd            (cmd),
        .status         (status),
        .roll_rate_rad  (roll_rad),
        .pitch_rate_rad (pitch_rad),
        .yaw_rate_rad   (yaw_rad),
        .roll_rate_deg  (roll_deg),
        .pitch_rate_deg (pitch_deg),
        .yaw_rate_deg   (yaw_deg)
    );

    assign m_tdata = OUT_TDW'({yaw_deg, pitch_deg, roll_deg, yaw_rad, pitch_rad, roll_rad});

endmodule

[design/brei_checker.sv]
// Port-level checks for the body rate integrator, bound to the top level.
`timescale 1ns / 1ps
`include "body_rate_euler_integrator_macros.svh"
module brei_checker #(
    parameter int OUT_W = 192
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    `BREI_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `BREI_ASSERT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    `BREI_ASSERT(a_one_item, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second beat taken while busy")
    `BREI_ASSERT(a_no_instant, aclk, aresetn, s_tvalid && s_tready && !m_tvalid |=> !m_tvalid, "result appeared one cycle after accept")
    `BREI_ASSERT_NR(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind body_rate_euler_integrator brei_checker #(
    .OUT_W (OUT_TDW)
) u_brei_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
